// ----- hdl/hk2ps2_pkg.sv -----
// shared types, constants and usage tables for the hid to ps/2 set 1 translator
package hk2ps2_pkg;

   localparam int KEY_SLOTS = 6;
   localparam int EV_COUNT  = 8 + 2 * KEY_SLOTS;

   localparam logic [7:0] EXT_PREFIX = 8'hE0;
   localparam logic [7:0] BREAK_BIT  = 8'h80;

   typedef logic [8:0] code_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PREFIX,
      ST_CODE
   } state_type;

   function automatic code_type modifier_code(input logic [2:0] idx);
      code_type c;
      case (idx)
         3'd0: c = 9'h01D;
         3'd1: c = 9'h02A;
         3'd2: c = 9'h038;
         3'd3: c = 9'h15B;
         3'd4: c = 9'h11D;
         3'd5: c = 9'h036;
         3'd6: c = 9'h138;
         3'd7: c = 9'h15C;
         default: c = 9'h000;
      endcase
      return c;
   endfunction

   function automatic code_type usage_code(input logic [7:0] u);
      code_type c;
      case (u)
         8'h04: c = 9'h01E; 8'h05: c = 9'h030; 8'h06: c = 9'h02E; 8'h07: c = 9'h020;
         8'h08: c = 9'h012; 8'h09: c = 9'h021; 8'h0A: c = 9'h022; 8'h0B: c = 9'h023;
         8'h0C: c = 9'h017; 8'h0D: c = 9'h024; 8'h0E: c = 9'h025; 8'h0F: c = 9'h026;
         8'h10: c = 9'h032; 8'h11: c = 9'h031; 8'h12: c = 9'h018; 8'h13: c = 9'h019;
         8'h14: c = 9'h010; 8'h15: c = 9'h013; 8'h16: c = 9'h01F; 8'h17: c = 9'h014;
         8'h18: c = 9'h016; 8'h19: c = 9'h02F; 8'h1A: c = 9'h011; 8'h1B: c = 9'h02D;
         8'h1C: c = 9'h015; 8'h1D: c = 9'h02C;
         8'h1E: c = 9'h002; 8'h1F: c = 9'h003; 8'h20: c = 9'h004; 8'h21: c = 9'h005;
         8'h22: c = 9'h006; 8'h23: c = 9'h007; 8'h24: c = 9'h008; 8'h25: c = 9'h009;
         8'h26: c = 9'h00A; 8'h27: c = 9'h00B;
         8'h28: c = 9'h01C; 8'h29: c = 9'h001; 8'h2A: c = 9'h00E; 8'h2B: c = 9'h00F;
         8'h2C: c = 9'h039; 8'h2D: c = 9'h00C; 8'h2E: c = 9'h00D; 8'h2F: c = 9'h01A;
         8'h30: c = 9'h01B; 8'h31: c = 9'h02B; 8'h32: c = 9'h02B; 8'h33: c = 9'h027;
         8'h34: c = 9'h028; 8'h35: c = 9'h029; 8'h36: c = 9'h033; 8'h37: c = 9'h034;
         8'h38: c = 9'h035; 8'h39: c = 9'h03A;
         8'h3A: c = 9'h03B; 8'h3B: c = 9'h03C; 8'h3C: c = 9'h03D; 8'h3D: c = 9'h03E;
         8'h3E: c = 9'h03F; 8'h3F: c = 9'h040; 8'h40: c = 9'h041; 8'h41: c = 9'h042;
         8'h42: c = 9'h043; 8'h43: c = 9'h044; 8'h44: c = 9'h057; 8'h45: c = 9'h058;
         8'h46: c = 9'h137; 8'h47: c = 9'h046; 8'h48: c = 9'h045; 8'h49: c = 9'h152;
         8'h4A: c = 9'h147; 8'h4B: c = 9'h149; 8'h4C: c = 9'h153; 8'h4D: c = 9'h14F;
         8'h4E: c = 9'h151; 8'h4F: c = 9'h14D; 8'h50: c = 9'h14B; 8'h51: c = 9'h150;
         8'h52: c = 9'h148; 8'h53: c = 9'h045; 8'h54: c = 9'h135; 8'h55: c = 9'h037;
         8'h56: c = 9'h04A; 8'h57: c = 9'h04E; 8'h58: c = 9'h11C;
         8'h59: c = 9'h04F; 8'h5A: c = 9'h050; 8'h5B: c = 9'h051; 8'h5C: c = 9'h04B;
         8'h5D: c = 9'h04C; 8'h5E: c = 9'h04D; 8'h5F: c = 9'h047; 8'h60: c = 9'h048;
         8'h61: c = 9'h049; 8'h62: c = 9'h052; 8'h63: c = 9'h053; 8'h64: c = 9'h056;
         8'h65: c = 9'h15F;
         8'hE0, 8'hE1, 8'hE2, 8'hE3, 8'hE4, 8'hE5, 8'hE6, 8'hE7:
            c = modifier_code(u[2:0]);
         default: c = 9'h000;
      endcase
      return c;
   endfunction

endpackage

// ----- hdl/hid_keyboard_to_ps2_set1.sv -----
// top level: hid boot keyboard report to ps/2 set 1 scancode byte stream
// Usage: one report transfers on req_ (modifiers and six key usages). The
// block compares it with the previous report and emits ps/2 set 1 bytes on
// rsp_, one byte per transfer, rsp_last_byte marking the last byte of the
// report. A report with no change emits nothing.
// Lanes compare every slot in parallel, combinationally; a sequencer then walks
// the 20 event slots (8 modifier bits, 6 breaks, 6 makes), one slot per
// cycle while no slot fires; a firing slot also passes the prefix state (for
// extended codes) and the code state, which wait while the receiver stalls.
// A report can cause at most 36 bytes.
// req_ready is high only while idle; one report is handled at a time.
// Reset clears the stored previous report to zero and drops any pending work.
// When the receiver stalls, the current byte holds on rsp_ and the sequencer
// waits; nothing is lost.
module hid_keyboard_to_ps2_set1 (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_modifiers,
   input  logic [7:0] req_key_slot_0,
   input  logic [7:0] req_key_slot_1,
   input  logic [7:0] req_key_slot_2,
   input  logic [7:0] req_key_slot_3,
   input  logic [7:0] req_key_slot_4,
   input  logic [7:0] req_key_slot_5,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_scancode_byte,
   output logic       rsp_last_byte
);
   localparam int K = hk2ps2_pkg::KEY_SLOTS;
   localparam int N = hk2ps2_pkg::EV_COUNT;
   localparam int IW = $clog2(N);

   hk2ps2_pkg::state_type state_ff, state_in;
   logic [7:0] prior_mods_ff;
   logic [K-1:0][7:0] prior_keys_ff;
   logic [N-1:0] fire_ff, fire_in;
   hk2ps2_pkg::code_type [N-1:0] code_ff;
   logic [N-1:0] make_ff;
   logic [IW-1:0] idx_ff, idx_in;
   logic [7:0] byte_ff, byte_in;
   logic last_ff, last_in, out_valid_ff, out_valid_in;

   logic [K-1:0][7:0] keys_now;
   logic [N-1:0] ev_fire, ev_make;
   hk2ps2_pkg::code_type [N-1:0] ev_code;
   logic [N-1:0] rest_mask;
   logic rest_any;
   hk2ps2_pkg::code_type cur_code;

   assign keys_now = {req_key_slot_5, req_key_slot_4, req_key_slot_3,
                      req_key_slot_2, req_key_slot_1, req_key_slot_0};

   hk2ps2_merge u_merge (
      .mods_now(req_modifiers), .mods_was(prior_mods_ff),
      .keys_now(keys_now), .keys_was(prior_keys_ff),
      .ev_fire(ev_fire), .ev_code(ev_code), .ev_make(ev_make)
   );

   assign req_ready = (state_ff == hk2ps2_pkg::ST_IDLE);
   assign rsp_valid = out_valid_ff;
   assign rsp_scancode_byte = byte_ff;
   assign rsp_last_byte = last_ff;
   assign cur_code = code_ff[idx_ff];

   // any event after the current one still pending
   always_comb begin
      for (int i = 0; i < N; i++) rest_mask[i] = (IW'(i) > idx_ff);
      rest_any = |(fire_ff & rest_mask);
   end

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      fire_in = fire_ff;
      byte_in = byte_ff;
      last_in = last_ff;
      out_valid_in = out_valid_ff;
      if (out_valid_ff && rsp_ready) out_valid_in = 1'b0;
      case (state_ff)
         hk2ps2_pkg::ST_IDLE: begin
            if (req_valid) begin
               fire_in = ev_fire;
               idx_in = '0;
               state_in = hk2ps2_pkg::ST_SCAN;
            end
         end
         hk2ps2_pkg::ST_SCAN: begin
            if (!fire_ff[idx_ff]) begin
               if (idx_ff == IW'(N - 1)) state_in = hk2ps2_pkg::ST_IDLE;
               else idx_in = idx_ff + 1'b1;
            end else if (cur_code[8]) begin
               state_in = hk2ps2_pkg::ST_PREFIX;
            end else begin
               state_in = hk2ps2_pkg::ST_CODE;
            end
         end
         hk2ps2_pkg::ST_PREFIX: begin
            if (!out_valid_ff || rsp_ready) begin
               out_valid_in = 1'b1;
               byte_in = hk2ps2_pkg::EXT_PREFIX;
               last_in = 1'b0;
               state_in = hk2ps2_pkg::ST_CODE;
            end
         end
         hk2ps2_pkg::ST_CODE: begin
            if (!out_valid_ff || rsp_ready) begin
               out_valid_in = 1'b1;
               byte_in = make_ff[idx_ff] ? cur_code[7:0]
                                         : (cur_code[7:0] | hk2ps2_pkg::BREAK_BIT);
               last_in = !rest_any;
               if (idx_ff == IW'(N - 1)) state_in = hk2ps2_pkg::ST_IDLE;
               else begin
                  idx_in = idx_ff + 1'b1;
                  state_in = hk2ps2_pkg::ST_SCAN;
               end
            end
         end
         default: state_in = hk2ps2_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hk2ps2_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
         prior_mods_ff <= '0;
         prior_keys_ff <= '0;
         idx_ff <= '0;
         fire_ff <= '0;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
         idx_ff <= idx_in;
         fire_ff <= fire_in;
         if (req_valid && req_ready) begin
            prior_mods_ff <= req_modifiers;
            prior_keys_ff <= keys_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
      if (req_valid && req_ready) begin
         code_ff <= ev_code;
         make_ff <= ev_make;
      end
   end
endmodule

// ----- hdl/hk2ps2_lane.sv -----
// one key lane: checks one slot against the other report and maps its usage
module hk2ps2_lane (
   input  logic [7:0]                      key,
   input  logic [hk2ps2_pkg::KEY_SLOTS-1:0][7:0] other,
   output logic                            fire,
   output hk2ps2_pkg::code_type            code
);
   logic held;

   always_comb begin
      held = 1'b0;
      for (int j = 0; j < hk2ps2_pkg::KEY_SLOTS; j++) begin
         if (other[j] == key) held = 1'b1;
      end
      code = hk2ps2_pkg::usage_code(key);
      fire = (key != 8'h00) && (key != 8'h01) && !held && (code != 9'h000);
   end
endmodule

// ----- hdl/hk2ps2_merge.sv -----
// event list builder: modifier changes, breaks and makes in emission order
module hk2ps2_merge (
   input  logic [7:0]                            mods_now,
   input  logic [7:0]                            mods_was,
   input  logic [hk2ps2_pkg::KEY_SLOTS-1:0][7:0] keys_now,
   input  logic [hk2ps2_pkg::KEY_SLOTS-1:0][7:0] keys_was,
   output logic [hk2ps2_pkg::EV_COUNT-1:0]       ev_fire,
   output hk2ps2_pkg::code_type [hk2ps2_pkg::EV_COUNT-1:0] ev_code,
   output logic [hk2ps2_pkg::EV_COUNT-1:0]       ev_make
);
   localparam int K = hk2ps2_pkg::KEY_SLOTS;
   logic [K-1:0] brk_fire, mk_fire;
   hk2ps2_pkg::code_type [K-1:0] brk_code, mk_code;

   for (genvar i = 0; i < K; i++) begin : g_lane
      hk2ps2_lane u_brk (
         .key(keys_was[i]), .other(keys_now), .fire(brk_fire[i]), .code(brk_code[i])
      );
      hk2ps2_lane u_mk (
         .key(keys_now[i]), .other(keys_was), .fire(mk_fire[i]), .code(mk_code[i])
      );
   end

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         ev_fire[i] = mods_now[i] ^ mods_was[i];
         ev_code[i] = hk2ps2_pkg::modifier_code(3'(i));
         ev_make[i] = mods_now[i];
      end
      for (int i = 0; i < K; i++) begin
         ev_fire[8+i]   = brk_fire[i];
         ev_code[8+i]   = brk_code[i];
         ev_make[8+i]   = 1'b0;
         ev_fire[8+K+i] = mk_fire[i];
         ev_code[8+K+i] = mk_code[i];
         ev_make[8+K+i] = 1'b1;
      end
   end
endmodule

// ----- tb/hid_keyboard_to_ps2_set1_tb.sv -----
// testbench for the hid report to ps/2 set 1 scancode translator
module hid_keyboard_to_ps2_set1_tb;

   typedef struct packed {
      logic [7:0] scancode_byte;
      logic       last_byte;
   } ps2_byte_type;

   typedef struct {
      logic [7:0] modifiers;
      logic [7:0] keys [hk2ps2_pkg::KEY_SLOTS];
   } report_type;

   class scancode_scoreboard;
      logic [7:0] held_mods;
      logic [7:0] held_keys [hk2ps2_pkg::KEY_SLOTS];
      ps2_byte_type pending [$];
      int         errors;

      function new();
         held_mods = '0;
         foreach (held_keys[i]) held_keys[i] = '0;
         errors = 0;
      endfunction

      // independent copy of the set 1 mapping
      function logic [8:0] lookup(input logic [7:0] u);
         logic [8:0] ctab [0:101];
         logic [8:0] mtab [0:7];
         ctab = '{9'h000, 9'h000, 9'h000, 9'h000,
            9'h01E, 9'h030, 9'h02E, 9'h020, 9'h012, 9'h021, 9'h022, 9'h023,
            9'h017, 9'h024, 9'h025, 9'h026, 9'h032, 9'h031, 9'h018, 9'h019,
            9'h010, 9'h013, 9'h01F, 9'h014, 9'h016, 9'h02F, 9'h011, 9'h02D,
            9'h015, 9'h02C, 9'h002, 9'h003, 9'h004, 9'h005, 9'h006, 9'h007,
            9'h008, 9'h009, 9'h00A, 9'h00B, 9'h01C, 9'h001, 9'h00E, 9'h00F,
            9'h039, 9'h00C, 9'h00D, 9'h01A, 9'h01B, 9'h02B, 9'h02B, 9'h027,
            9'h028, 9'h029, 9'h033, 9'h034, 9'h035, 9'h03A, 9'h03B, 9'h03C,
            9'h03D, 9'h03E, 9'h03F, 9'h040, 9'h041, 9'h042, 9'h043, 9'h044,
            9'h057, 9'h058, 9'h137, 9'h046, 9'h045, 9'h152, 9'h147, 9'h149,
            9'h153, 9'h14F, 9'h151, 9'h14D, 9'h14B, 9'h150, 9'h148, 9'h045,
            9'h135, 9'h037, 9'h04A, 9'h04E, 9'h11C, 9'h04F, 9'h050, 9'h051,
            9'h04B, 9'h04C, 9'h04D, 9'h047, 9'h048, 9'h049, 9'h052, 9'h053,
            9'h056, 9'h15F};
         mtab = '{9'h01D, 9'h02A, 9'h038, 9'h15B, 9'h11D, 9'h036, 9'h138, 9'h15C};
         if (u < 8'h66) return ctab[u];
         if (u >= 8'hE0 && u <= 8'hE7) return mtab[u[2:0]];
         return 9'h000;
      endfunction

      function void emit(input logic [8:0] code, input bit make,
                         ref ps2_byte_type seq [$]);
         if (code == 0) return;
         if (code[8]) seq.push_back('{hk2ps2_pkg::EXT_PREFIX, 1'b0});
         seq.push_back('{make ? code[7:0] : (code[7:0] | hk2ps2_pkg::BREAK_BIT), 1'b0});
      endfunction

      function void note_report(input report_type r);
         ps2_byte_type seq [$];
         logic [8:0] mtab [0:7];
         bit found;
         mtab = '{9'h01D, 9'h02A, 9'h038, 9'h15B, 9'h11D, 9'h036, 9'h138, 9'h15C};
         for (int i = 0; i < 8; i++)
            if (held_mods[i] != r.modifiers[i]) emit(mtab[i], r.modifiers[i], seq);
         for (int i = 0; i < hk2ps2_pkg::KEY_SLOTS; i++) begin
            if (held_keys[i] <= 8'h01) continue;
            found = 0;
            for (int j = 0; j < hk2ps2_pkg::KEY_SLOTS; j++)
               if (r.keys[j] == held_keys[i]) found = 1;
            if (!found) emit(lookup(held_keys[i]), 0, seq);
         end
         for (int i = 0; i < hk2ps2_pkg::KEY_SLOTS; i++) begin
            if (r.keys[i] <= 8'h01) continue;
            found = 0;
            for (int j = 0; j < hk2ps2_pkg::KEY_SLOTS; j++)
               if (held_keys[j] == r.keys[i]) found = 1;
            if (!found) emit(lookup(r.keys[i]), 1, seq);
         end
         held_mods = r.modifiers;
         foreach (held_keys[i]) held_keys[i] = r.keys[i];
         if (seq.size() > 0) seq[seq.size()-1].last_byte = 1'b1;
         foreach (seq[i]) pending.push_back(seq[i]);
      endfunction

      function void check_byte(input logic [7:0] sc, input logic lb);
         ps2_byte_type e;
         if (pending.size() == 0) begin
            $error("unexpected scancode byte %h", sc);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (sc !== e.scancode_byte) begin
            $error("scancode_byte expected %h actual %h", e.scancode_byte, sc);
            errors++;
         end
         if (lb !== e.last_byte) begin
            $error("last_byte expected %b actual %b", e.last_byte, lb);
            errors++;
         end
      endfunction
   endclass

   logic       clock, reset;
   logic       req_valid, req_ready, rsp_valid, rsp_ready, rsp_last_byte;
   logic [7:0] req_modifiers, req_key_slot_0, req_key_slot_1, req_key_slot_2;
   logic [7:0] req_key_slot_3, req_key_slot_4, req_key_slot_5, rsp_scancode_byte;

   scancode_scoreboard sb;
   bit calm;
   report_type cur;

   hid_keyboard_to_ps2_set1 dut (.*);

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("hid_keyboard_to_ps2_set1 regression: fail");
      $finish;
   end

   // receiver with random stalls
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= calm || ($urandom_range(99) >= 10);
      if (!reset && rsp_valid && rsp_ready) sb.check_byte(rsp_scancode_byte, rsp_last_byte);
   end

   task automatic send_report(input report_type r);
      while (!calm && $urandom_range(99) < 10) @(posedge clock);
      req_valid      <= 1'b1;
      req_modifiers  <= r.modifiers;
      req_key_slot_0 <= r.keys[0];
      req_key_slot_1 <= r.keys[1];
      req_key_slot_2 <= r.keys[2];
      req_key_slot_3 <= r.keys[3];
      req_key_slot_4 <= r.keys[4];
      req_key_slot_5 <= r.keys[5];
      do @(posedge clock); while (!req_ready);
      sb.note_report(r);
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_fields(input logic [7:0] m, input logic [7:0] k0, k1, k2, k3, k4, k5);
      report_type r;
      r.modifiers = m;
      r.keys = '{k0, k1, k2, k3, k4, k5};
      send_report(r);
   endtask

   function automatic logic [7:0] pick_usage();
      int s = $urandom_range(99);
      if (s < 15) return 8'h00;
      if (s < 20) return 8'h01;
      if (s < 75) return 8'($urandom_range(8'h65, 8'h04));
      if (s < 85) return 8'($urandom_range(8'hE7, 8'hE0));
      return 8'($urandom_range(255));
   endfunction

   initial begin
      sb = new();
      calm = 0;
      reset = 1; req_valid = 0;
      req_modifiers = 0; req_key_slot_0 = 0; req_key_slot_1 = 0; req_key_slot_2 = 0;
      req_key_slot_3 = 0; req_key_slot_4 = 0; req_key_slot_5 = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: no change, all modifiers, extended keys, duplicates, unmapped
      send_fields(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      send_fields(8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      send_fields(8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      send_fields(8'h00, 8'h04, 8'h46, 8'h58, 8'h65, 8'hE3, 8'hE7);
      send_fields(8'h55, 8'h04, 8'h04, 8'h02, 8'h03, 8'h66, 8'hFF);
      send_fields(8'hAA, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01);
      send_fields(8'h00, 8'h49, 8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E);
      send_fields(8'h00, 8'h4F, 8'h50, 8'h51, 8'h52, 8'h54, 8'hE0);
      send_fields(8'h0F, 8'hE8, 8'hDF, 8'h29, 8'h2C, 8'h39, 8'h64);
      send_fields(8'hF0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      send_fields(8'h00, 8'h80, 8'h7F, 8'hE4, 8'hE6, 8'h53, 8'h63);
      send_fields(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);

      for (int n = 0; n < 180; n++) begin
         if (n == 60) begin
            // hold the sender until the stream drains
            while (sb.pending.size() != 0) @(posedge clock);
            repeat (30) @(posedge clock);
         end
         calm = (n >= 100 && n < 130);
         cur.modifiers = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : sb.held_mods;
         if ($urandom_range(3) == 0) cur.modifiers[$urandom_range(7)] ^= 1'b1;
         // mostly keep some held keys so breaks and holds both occur
         foreach (cur.keys[i])
            cur.keys[i] = ($urandom_range(1) == 0) ? sb.held_keys[$urandom_range(5)]
                                                   : pick_usage();
         send_report(cur);
      end
      calm = 0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("hid_keyboard_to_ps2_set1 regression: pass");
      else
         $display("hid_keyboard_to_ps2_set1 regression: fail");
      $finish;
   end
endmodule
